// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define MT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true out of reset.
`define MT_ASSERT_NEVER(name, cond, msg) \
  `MT_ASSERT(name, !(cond), msg)

`endif

// ----- hdl/mt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mt_pkg
// Types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int STATE_DEPTH   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int WORD_W        = 32;
  localparam int IDX_W         = $clog2(STATE_DEPTH + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Command codes on in_cmd
  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_t;

  localparam word_t TWIST_MATRIX = 32'h9908_B0DF;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7FFF_FFFF;
  localparam word_t ALL_ONES     = 32'hFFFF_FFFF;

  localparam idx_t IDX_LAST  = idx_t'(STATE_DEPTH - 1);
  localparam idx_t MID_FWD   = idx_t'(MIDDLE_OFFSET);
  localparam idx_t MID_BACK  = idx_t'(STATE_DEPTH - MIDDLE_OFFSET);
  localparam idx_t RETRY_MAX = idx_t'(STATE_DEPTH);

  // New state word from s[k], s[k+1] and s[k+397].
  function automatic word_t twist_word(word_t cur, word_t nxt, word_t mid);
    word_t joined;
    word_t shifted;
    joined  = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    shifted = joined >> 1;
    if (joined[0]) begin
      shifted = shifted ^ TWIST_MATRIX;
    end
    return mid ^ shifted;
  endfunction

  function automatic word_t temper_word(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/mersenne_twister_prng.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_prng
// MT19937 generator: seed command fills the 624-word state, draw command
// returns one tempered word (never all ones).
// ----------------------------------------------------------------------------
//  channel  | ports                               | transfer when
//  ---------+-------------------------------------+-------------------------
//  command  | in_cmd, in_seed_value               | start && !busy
//  result   | out_random_word                     | out_valid (one cycle)
//
// Seed: busy while each state word after s[0] is built: multiply, then add index.
// Draw: per tried word, read s[k+1], read s[k+397], twist, temper; out_valid
//   is registered from the temper step. An all-ones word is retried, up to
//   624 retries; busy stays high until the draw is done.
// The single read port of the state RAM puts the two reads in separate steps.
// Reset clears control only; the state RAM holds garbage until seeded.
// Results cannot be stalled; a new command may transfer while out_valid is up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mersenne_twister_prng (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_cmd,
  input  wire mt_pkg::word_t in_seed_value,
  output logic               out_valid,
  output mt_pkg::word_t      out_random_word
);
  import mt_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_MUL = 3'd1;
  localparam logic [2:0] ST_SEED_ADD = 3'd2;
  localparam logic [2:0] ST_RD_A     = 3'd3;
  localparam logic [2:0] ST_RD_B     = 3'd4;
  localparam logic [2:0] ST_CALC     = 3'd5;
  localparam logic [2:0] ST_TEMPER   = 3'd6;

  // Control state
  logic [2:0] state_r, state_nxt;
  idx_t       idx_r, idx_nxt;     // next word to hand out (twisted lazily)
  idx_t       cnt_r, cnt_nxt;     // seed word index, or retry count on draws
  logic       out_valid_r, out_valid_nxt;

  // Datapath
  word_t prev_r, prev_nxt;        // previous seed word
  word_t prod_r, prod_nxt;        // seed multiply result
  word_t cur_r, cur_nxt;          // s[k], already read or known
  word_t next_r, next_nxt;        // s[k+1]
  word_t y_r, y_nxt;              // freshly twisted word
  word_t out_word_r, out_word_nxt;

  // RAM port
  logic  ram_we;
  idx_t  ram_waddr, ram_raddr;
  word_t ram_wdata, ram_rdata;

  idx_t  idx_inc, idx_mid;
  word_t seed_mix, temp_w;
  logic  take;

  mt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign take     = start && (state_r == ST_IDLE);
  assign idx_inc  = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign idx_mid  = (idx_r < MID_BACK) ? idx_r + MID_FWD : idx_r - MID_BACK;
  assign seed_mix = prev_r ^ (prev_r >> 30);
  assign temp_w   = temper_word(y_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    y_nxt         = y_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = y_r;
    ram_raddr     = idx_inc;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cnt_nxt = '0;
          if (in_cmd == CMD_SEED) begin
            // s[0] = seed; s[0] also primes the twist's s[k] register.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_seed_value;
            prev_nxt  = in_seed_value;
            cur_nxt   = in_seed_value;
            idx_nxt   = '0;
            cnt_nxt   = idx_t'(1);
            state_nxt = ST_SEED_MUL;
          end else begin
            state_nxt = ST_RD_A;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = seed_mix * SEED_MULT;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = prod_r + word_t'(cnt_r);
        prev_nxt  = prod_r + word_t'(cnt_r);
        if (cnt_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_RD_A: begin
        ram_raddr = idx_inc;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = idx_mid;
        next_nxt  = ram_rdata;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        y_nxt     = twist_word(cur_r, next_r, ram_rdata);
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = twist_word(cur_r, next_r, ram_rdata);
        cur_nxt   = next_r;
        idx_nxt   = idx_inc;
        state_nxt = ST_TEMPER;
      end
      ST_TEMPER: begin
        if ((temp_w == ALL_ONES) && (cnt_r != RETRY_MAX)) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_RD_A;
        end else begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = (temp_w == ALL_ONES) ? ALL_ONES - 1'b1 : temp_w;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;      // lazy twist: position 624 == twist word 0 next
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    y_r        <= y_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  `MT_ASSERT(a_no_all_ones, out_valid |-> (out_random_word != ALL_ONES), "all-ones result")
  `MT_ASSERT(a_valid_from_temper, out_valid |-> ($past(state_r) == ST_TEMPER), "stray result")
  `MT_ASSERT_NEVER(a_idx_range, idx_r > IDX_LAST, "position out of range")
  `MT_ASSERT_NEVER(a_rw_clash, ram_we && (state_r == ST_CALC) && (ram_raddr == ram_waddr), "RAM clash")

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mersenne_twister_prng: a queue of seed and draw
// commands feeds a clocked driver, a golden MT19937 model runs on every
// command transfer, and a clocked monitor checks each strobed word in order.
// ----------------------------------------------------------------------------
module tb;

  import mt_pkg::*;

  // One pending command: payload, idle cycles before it is offered, and a
  // flag that holds it back until every outstanding draw has returned.
  typedef struct {
    cmd_t        cmd;
    word_t       seed;
    int unsigned gap;
    bit          drain;
  } mt_item_t;

  localparam int CLK_HALF = 4;
  localparam int RST_CYCLES = 12;
  // Budget per command: a draw that retries through all 624 words, plus a full
  // seed walk, plus the longest sender gap; taken 4x over.
  localparam longint LIMIT_CYCLES =
    longint'(1100) * (4 * (STATE_DEPTH + 1) + 2 * STATE_DEPTH + 16) * 4;
  localparam int TAIL_CYCLES = 64;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  in_cmd = CMD_DRAW;
  word_t in_seed_value = '0;
  logic  out_valid;
  word_t out_random_word;

  mersenne_twister_prng u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Golden generator: own copy of the 624-word state and the read position.
  // --------------------------------------------------------------------------
  word_t       gm_words [STATE_DEPTH];
  int unsigned gm_pos = STATE_DEPTH;

  function automatic void gm_seed(word_t seed);
    word_t prev;
    gm_words[0] = seed;
    for (int k = 1; k < STATE_DEPTH; k++) begin
      prev = gm_words[k-1];
      // 32-bit operands: the product wraps mod 2^32 like the hardware
      gm_words[k] = (prev ^ (prev >> 30)) * SEED_MULT + word_t'(k);
    end
    gm_pos = STATE_DEPTH;
  endfunction

  function automatic void gm_twist();
    word_t joined;
    word_t shifted;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      joined  = (gm_words[k] & HIGH_BIT) | (gm_words[(k + 1) % STATE_DEPTH] & LOW_BITS);
      shifted = joined >> 1;
      if (joined[0]) begin
        shifted = shifted ^ TWIST_MATRIX;
      end
      gm_words[k] = gm_words[(k + MIDDLE_OFFSET) % STATE_DEPTH] ^ shifted;
    end
    gm_pos = 0;
  endfunction

  // Next tempered word; twists first once the position has run off the end.
  function automatic word_t gm_next();
    word_t y;
    if (gm_pos >= STATE_DEPTH) begin
      gm_twist();
    end
    y = gm_words[gm_pos];
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    gm_pos++;
    return y;
  endfunction

  // One draw command: all-ones words are skipped, at most 624 retries,
  // and a word still all ones after that comes out as all ones minus one.
  function automatic word_t gm_draw();
    word_t w;
    int    tries;
    w = gm_next();
    tries = 0;
    while (w == ALL_ONES && tries < STATE_DEPTH) begin
      w = gm_next();
      tries++;
    end
    if (w == ALL_ONES) begin
      w = ALL_ONES - 1;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // --------------------------------------------------------------------------
  mt_item_t    pending [$];
  word_t       expected_words [$];
  int unsigned hold_cnt = 0;
  int unsigned draws_sent = 0;    // driver side, nonblocking
  int unsigned results_seen = 0;  // monitor side, nonblocking
  int unsigned error_cnt = 0;

  function automatic void add_item(cmd_t cmd, word_t seed, int unsigned gap, bit drain);
    mt_item_t it;
    it.cmd   = cmd;
    it.seed  = seed;
    it.gap   = gap;
    it.drain = drain;
    pending.push_back(it);
  endfunction

  function automatic int unsigned rand_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  // Seed values lean on the extremes now and then, otherwise fully random.
  function automatic word_t rand_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return HIGH_BIT;
      3:       return LOW_BITS;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver. At each edge: a command transfers when start && !busy; the golden
  // model is advanced on that transfer and a draw queues its expected word.
  // When the slot is free the next command is offered after its gap. A
  // drained command waits until sent draws equal received results; the draw
  // transferring on this very edge is counted in via sent_now.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    mt_item_t    it;
    int unsigned sent_now;
    if (!rst_n) begin
      start         <= 1'b0;
      in_cmd        <= CMD_DRAW;
      in_seed_value <= '0;
      hold_cnt       = 0;
      draws_sent    <= 0;
    end else begin
      sent_now = draws_sent;
      if (start && !busy) begin
        if (in_cmd == CMD_SEED) begin
          gm_seed(in_seed_value);
        end else begin
          expected_words.push_back(gm_draw());
          sent_now = draws_sent + 1;
          draws_sent <= sent_now;
        end
      end
      if (!start || !busy) begin
        if (pending.size() == 0 || (pending[0].drain && sent_now != results_seen)) begin
          start <= 1'b0;
        end else if (hold_cnt < pending[0].gap) begin
          hold_cnt++;
          start <= 1'b0;
        end else begin
          it = pending.pop_front();
          hold_cnt = 0;
          start         <= 1'b1;
          in_cmd        <= it.cmd;
          in_seed_value <= it.seed;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed word is a transfer; compare with the oldest
  // expectation. Results cannot be back-pressured, so nothing to drive here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    word_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_words.size() == 0) begin
        $error("out_random_word: expected none, actual %h", out_random_word);
        error_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (out_random_word !== want) begin
          $error("out_random_word: expected %h, actual %h", want, out_random_word);
          error_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command list, reset, and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int    total;
    int    run_len;
    bit    burst;

    // Directed: the very first command is a seed, so the state RAM is never
    // read before it is written.
    add_item(CMD_SEED, 32'd5489, 0, 1'b0);         // the classic default seed
    add_item(CMD_DRAW, '0, 0, 1'b0);               // first draw twists first
    add_item(CMD_DRAW, ALL_ONES, 0, 1'b0);         // seed field ignored on draw
    add_item(CMD_DRAW, 32'h5555_5555, 3, 1'b0);
    add_item(CMD_SEED, '0, 0, 1'b0);               // seed right behind a draw
    add_item(CMD_DRAW, 32'hAAAA_AAAA, 4, 1'b0);
    add_item(CMD_DRAW, '0, 0, 1'b0);
    add_item(CMD_SEED, ALL_ONES, 1, 1'b0);
    add_item(CMD_DRAW, '0, 0, 1'b0);
    add_item(CMD_SEED, HIGH_BIT, 0, 1'b0);
    add_item(CMD_SEED, 32'd1, 0, 1'b0);            // back-to-back seeds
    add_item(CMD_DRAW, '0, 0, 1'b0);
    add_item(CMD_DRAW, '0, 0, 1'b0);
    add_item(CMD_DRAW, '0, 2, 1'b1);               // sender drains first
    add_item(CMD_SEED, LOW_BITS, 0, 1'b1);         // reseed with pipe empty
    add_item(CMD_DRAW, ALL_ONES, 0, 1'b0);
    add_item(CMD_SEED, 32'h0000_FFFF, 0, 1'b0);    // reseed mid-sequence
    add_item(CMD_DRAW, '0, 0, 1'b0);
    add_item(CMD_DRAW, '0, 1, 1'b0);
    // The all-ones retry path is not reachable from a practical seed; the
    // golden draw models it anyway.

    // Random: one long run past the 624-word boundary so the state twists
    // again mid-stream, then short seed+draw runs with mixed gap behavior.
    add_item(CMD_SEED, $urandom, 0, 1'b0);
    for (int i = 0; i < 700; i++) begin
      burst = (i / 50) % 3 == 0;
      add_item(CMD_DRAW, $urandom, rand_gap(burst), $urandom_range(0, 99) == 0);
    end
    total = 720;
    while (total < 1050) begin
      burst   = $urandom_range(0, 3) == 0;
      run_len = $urandom_range(1, 40);
      add_item(CMD_SEED, rand_seed(), rand_gap(burst), $urandom_range(0, 9) == 0);
      for (int i = 0; i < run_len; i++) begin
        add_item(CMD_DRAW, $urandom, rand_gap(burst), $urandom_range(0, 99) == 0);
      end
      total += run_len + 1;
    end
    // Close on a draw so the last transfer has a result to wait for.
    add_item(CMD_DRAW, $urandom, 0, 1'b0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    // Tail: a stray strobe after the last expected word would be flagged
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mt_pkg.sv
hdl/mt_ram.sv
hdl/mersenne_twister_prng.sv
dv/tb.sv
